@@ rtl/pse_pkg.sv @@
// ---------------------------------------------------------------------------
// pse_pkg: shared types, constants and functions of the stored-deflate PNG
// encoder (byte tables, CRC-32 step, sample and dimension conversion).
// ---------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

   localparam int MAX_DIMENSION = 16384;
   localparam int BLOCK_BYTES   = 65535;
   localparam int MAX_OUT       = 52;
   localparam int BQ_DEPTH      = 256;
   localparam int STEPQ_DEPTH   = 4;
   localparam int PIXQ_DEPTH    = 2;

   localparam int DIM_W   = 15;
   localparam int CNT_W   = 14;
   localparam int RAW_W   = 30;
   localparam int DIVD_W  = RAW_W + 1;
   localparam int BLK_W   = 16;
   localparam int OWED_W  = 9;
   localparam int QUOTA_W = 6;
   localparam int IDX_W   = 6;
   localparam int DCNT_W  = 5;

   localparam logic [15:0] ADLER_MOD = 16'd65521;
   localparam logic [31:0] CRC_POLY  = 32'hedb88320;
   localparam logic [31:0] CRC_INIT  = 32'hffffffff;

   // configuration register indexes
   localparam logic [1:0] CFG_WIDTH  = 2'd0;
   localparam logic [1:0] CFG_HEIGHT = 2'd1;

   // positions inside the 43-byte image preamble
   localparam logic [IDX_W-1:0] HP_CRC_FIRST = 6'd12;
   localparam logic [IDX_W-1:0] HP_WIDTH     = 6'd16;
   localparam logic [IDX_W-1:0] HP_HEIGHT    = 6'd20;
   localparam logic [IDX_W-1:0] HP_CRC_LAST  = 6'd28;
   localparam logic [IDX_W-1:0] HP_IHDR_CRC  = 6'd29;
   localparam logic [IDX_W-1:0] HP_ZLEN      = 6'd33;
   localparam logic [IDX_W-1:0] HP_IDAT      = 6'd37;
   localparam logic [IDX_W-1:0] HP_LAST      = 6'd42;

   // positions inside the 20-byte trailer
   localparam logic [IDX_W-1:0] TP_CRC  = 6'd4;
   localparam logic [IDX_W-1:0] TP_IEND = 6'd8;
   localparam logic [IDX_W-1:0] TP_LAST = 6'd19;

   typedef struct packed {
      logic       valid;
      logic       eof;
      logic [7:0] data;
   } pse_byte_type;

   typedef struct packed {
      logic               valid;
      logic [QUOTA_W-1:0] quota;
   } pse_step_type;

   typedef struct packed {
      logic byte_full;
      logic step_full;
   } pse_status_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pse_pixel_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
      end
      return r;
   endfunction

   // fixed bytes of the preamble; variable positions read as zero
   function automatic logic [7:0] head_const(input logic [IDX_W-1:0] idx);
      logic [7:0] r;
      case (idx)
         6'd0:    r = 8'd137;
         6'd1:    r = 8'd80;
         6'd2:    r = 8'd78;
         6'd3:    r = 8'd71;
         6'd4:    r = 8'd13;
         6'd5:    r = 8'd10;
         6'd6:    r = 8'd26;
         6'd7:    r = 8'd10;
         6'd11:   r = 8'd13;
         6'd12:   r = 8'h49;
         6'd13:   r = 8'h48;
         6'd14:   r = 8'h44;
         6'd15:   r = 8'h52;
         6'd24:   r = 8'd8;
         6'd25:   r = 8'd2;
         6'd37:   r = 8'h49;
         6'd38:   r = 8'h44;
         6'd39:   r = 8'h41;
         6'd40:   r = 8'h54;
         6'd41:   r = 8'h78;
         6'd42:   r = 8'h01;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] iend_byte(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd4:    r = 8'h49;
         4'd5:    r = 8'h45;
         4'd6:    r = 8'h4e;
         4'd7:    r = 8'h44;
         4'd8:    r = 8'hae;
         4'd9:    r = 8'h42;
         4'd10:   r = 8'h60;
         4'd11:   r = 8'h82;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   // big-endian byte sel of a word
   function automatic logic [7:0] be_byte(input logic [31:0] x, input logic [1:0] sel);
      logic [7:0] r;
      case (sel)
         2'd0:    r = x[31:24];
         2'd1:    r = x[23:16];
         2'd2:    r = x[15:8];
         default: r = x[7:0];
      endcase
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) r = DIM_W'(1);
      else if (d > DIM_W'(MAX_DIMENSION)) r = DIM_W'(MAX_DIMENSION);
      else r = d;
      return r;
   endfunction

   // clamp Q16 sample to [0,1] and round v*255 half up
   function automatic logic [7:0] to_byte(input logic [23:0] v);
      logic [24:0] prod;
      logic [7:0]  r;
      prod = ({8'd0, v[16:0]} << 8) - {8'd0, v[16:0]} + 25'd32768;
      if (v[23]) r = 8'd0;
      else if (v > 24'd65536) r = 8'd255;
      else r = prod[23:16];
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/pse_ram.sv @@
// ---------------------------------------------------------------------------
// pse_ram: generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/pse_regq.sv @@
// ---------------------------------------------------------------------------
// pse_regq: small register queue with the head visible at the output.
// ---------------------------------------------------------------------------
`default_nettype none

module pse_regq #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  head_valid,
   output logic      [WIDTH-1:0] head_data
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full       = (cnt_ff == (AW+1)'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) cnt_in = (AW+1)'(cnt_ff + 1'b1);
      else if (do_pop && !do_push) cnt_in = (AW+1)'(cnt_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pse_front.sv @@
// ---------------------------------------------------------------------------
// pse_front: accepts pixels, converts each sample to a byte and queues them.
// ---------------------------------------------------------------------------
`default_nettype none

module pse_front
   import pse_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [23:0]   req_red,
   input  wire logic [23:0]   req_green,
   input  wire logic [23:0]   req_blue,
   output logic               px_valid,
   output pse_pixel_type      px_data,
   input  wire logic          px_pop
);

   pse_pixel_type conv;
   logic          q_full;

   always_comb begin
      conv.red   = to_byte(req_red);
      conv.green = to_byte(req_green);
      conv.blue  = to_byte(req_blue);
   end

   assign req_stall = q_full;

   pse_regq #(
      .WIDTH ($bits(pse_pixel_type)),
      .DEPTH (PIXQ_DEPTH)
   ) u_pixq (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_data  (conv),
      .pop        (px_pop),
      .full       (q_full),
      .head_valid (px_valid),
      .head_data  (px_data)
   );

endmodule

`default_nettype wire

@@ rtl/pse_gen.sv @@
// ---------------------------------------------------------------------------
// pse_gen: byte sequencer. Builds the PNG stream one byte a cycle when not
// stalled, keeps CRC-32, Adler-32 and block framing, closes each pixel's run.
// ---------------------------------------------------------------------------
`default_nettype none

module pse_gen
   import pse_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [DIM_W-1:0] cfg_width,
   input  wire logic [DIM_W-1:0] cfg_height,
   input  wire logic             px_valid,
   input  pse_pixel_type         px_data,
   output logic                  px_pop,
   output pse_byte_type          byte_push,
   output pse_step_type          step_push,
   input  pse_status_type        status
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_HEAD = 4'b0010,
      S_RAW  = 4'b0100,
      S_TAIL = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      D_IDLE = 4'b0001,
      D_MUL  = 4'b0010,
      D_LOAD = 4'b0100,
      D_SUM  = 4'b1000
   } div_state_type;

   state_type          state_ff, state_in;
   div_state_type      dv_ff, dv_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [2:0]         hdr_ff, hdr_in;
   logic [31:0]        crc_ff, crc_in;
   logic [15:0]        alo_ff, alo_in;
   logic [15:0]        ahi_ff, ahi_in;
   logic [CNT_W-1:0]   col_ff, col_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic [RAW_W-1:0]   left_ff, left_in;
   logic [BLK_W-1:0]   blk_ff, blk_in;
   logic               started_ff, started_in;
   logic [OWED_W-1:0]  owed_ff, owed_in;
   logic [DIM_W-1:0]   lat_w_ff, lat_w_in;
   logic [DIM_W-1:0]   lat_h_ff, lat_h_in;
   logic [RAW_W-1:0]   raw_ff, raw_in;
   logic [DIVD_W-1:0]  dq_ff, dq_in;
   logic [31:0]        zlen_ff, zlen_in;
   logic               zlen_ok_ff, zlen_ok_in;

   logic               adv, push_b, end_step, crc_upd, crc_one;
   logic [7:0]         b_out, raw_b;
   logic               eof_b;
   logic [OWED_W-1:0]  total;
   logic [QUOTA_W-1:0] quota;
   logic [BLK_W-1:0]   n_blk;
   logic               fin_blk;
   logic [16:0]        lo_sum, hi_sum;
   logic [15:0]        lo_new, hi_new;
   logic [DIM_W-1:0]   col_nx, row_nx;
   logic [15:0]        three_w;
   logic [DIVD_W-1:0]  divx, dsum;
   logic [32:0]        zsum;
   logic [31:0]        crc_base;

   assign adv = !status.byte_full && !status.step_full;

   always_comb begin
      n_blk   = (left_ff < RAW_W'(BLOCK_BYTES)) ? left_ff[BLK_W-1:0] : BLK_W'(BLOCK_BYTES);
      fin_blk = (left_ff <= RAW_W'(BLOCK_BYTES));
      case (idx_ff[1:0])
         2'd0:    raw_b = 8'd0;
         2'd1:    raw_b = px_data.red;
         2'd2:    raw_b = px_data.green;
         default: raw_b = px_data.blue;
      endcase
      lo_sum  = {1'b0, alo_ff} + {9'd0, raw_b};
      lo_new  = (lo_sum >= {1'b0, ADLER_MOD}) ? 16'(lo_sum - {1'b0, ADLER_MOD}) : lo_sum[15:0];
      hi_sum  = {1'b0, ahi_ff} + {1'b0, lo_new};
      hi_new  = (hi_sum >= {1'b0, ADLER_MOD}) ? 16'(hi_sum - {1'b0, ADLER_MOD}) : hi_sum[15:0];
      col_nx  = DIM_W'({1'b0, col_ff} + 1'b1);
      row_nx  = DIM_W'({1'b0, row_ff} + 1'b1);
      three_w = 16'({lat_w_ff, 1'b0} + {1'b0, lat_w_ff} + 16'd1);
      // x / 65535 == (x + (x >> 16) + 1) >> 16 for x below 2^32
      divx    = DIVD_W'({1'b0, raw_ff} + DIVD_W'(BLOCK_BYTES - 1));
      dsum    = DIVD_W'(divx + {16'd0, divx[DIVD_W-1:16]} + DIVD_W'(1));
      zsum    = 33'd6 + {3'd0, raw_ff} + {dq_ff, 2'b00} + {2'd0, dq_ff};
   end

   always_comb begin
      state_in   = state_ff;
      dv_in      = dv_ff;
      idx_in     = idx_ff;
      hdr_in     = hdr_ff;
      alo_in     = alo_ff;
      ahi_in     = ahi_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      left_in    = left_ff;
      blk_in     = blk_ff;
      started_in = started_ff;
      lat_w_in   = lat_w_ff;
      lat_h_in   = lat_h_ff;
      raw_in     = raw_ff;
      dq_in      = dq_ff;
      zlen_in    = zlen_ff;
      zlen_ok_in = zlen_ok_ff;
      push_b     = 1'b0;
      end_step   = 1'b0;
      crc_upd    = 1'b0;
      crc_one    = 1'b0;
      b_out      = 8'd0;
      eof_b      = 1'b0;
      px_pop     = 1'b0;

      // IDAT length: raw = (3w+1)h, blocks = ceil(raw / BLOCK_BYTES)
      case (dv_ff)
         D_MUL: begin
            raw_in = {14'd0, three_w} * {15'd0, lat_h_ff};
            dv_in  = D_LOAD;
         end
         D_LOAD: begin
            dq_in = {16'd0, dsum[DIVD_W-1:16]};
            dv_in = D_SUM;
         end
         D_SUM: begin
            zlen_in    = zsum[31:0];
            zlen_ok_in = 1'b1;
            dv_in      = D_IDLE;
         end
         default: ;
      endcase

      case (state_ff)
         S_IDLE: begin
            if (px_valid && adv) begin
               if (started_ff) begin
                  state_in = S_RAW;
                  idx_in   = (col_ff == '0) ? IDX_W'(0) : IDX_W'(1);
               end else if (owed_ff == '0) begin
                  lat_w_in   = clamp_dim(cfg_width);
                  lat_h_in   = clamp_dim(cfg_height);
                  zlen_ok_in = 1'b0;
                  dv_in      = D_MUL;
                  state_in   = S_HEAD;
                  idx_in     = '0;
               end else begin
                  // backlog still draining: drop the pixel, release a run
                  end_step = 1'b1;
                  px_pop   = 1'b1;
               end
            end
         end
         S_HEAD: begin
            if (adv && !(idx_ff == HP_ZLEN && !zlen_ok_ff)) begin
               push_b = 1'b1;
               if (idx_ff >= HP_WIDTH && idx_ff < HP_HEIGHT)
                  b_out = be_byte({17'd0, lat_w_ff}, idx_ff[1:0]);
               else if (idx_ff >= HP_HEIGHT && idx_ff < HP_CRC_FIRST + 6'd12)
                  b_out = be_byte({17'd0, lat_h_ff}, idx_ff[1:0]);
               else if (idx_ff >= HP_IHDR_CRC && idx_ff < HP_ZLEN)
                  b_out = be_byte(~crc_ff, 2'(idx_ff - HP_IHDR_CRC));
               else if (idx_ff >= HP_ZLEN && idx_ff < HP_IDAT)
                  b_out = be_byte(zlen_ff, 2'(idx_ff - HP_ZLEN));
               else
                  b_out = head_const(idx_ff);
               crc_upd = (idx_ff >= HP_CRC_FIRST && idx_ff <= HP_CRC_LAST) ||
                         (idx_ff >= HP_IDAT);
               crc_one = (idx_ff == HP_CRC_FIRST) || (idx_ff == HP_IDAT);
               if (idx_ff == HP_LAST) begin
                  alo_in     = 16'd1;
                  ahi_in     = 16'd0;
                  col_in     = '0;
                  row_in     = '0;
                  blk_in     = '0;
                  hdr_in     = '0;
                  left_in    = raw_ff;
                  started_in = 1'b1;
                  state_in   = S_RAW;
                  idx_in     = '0;
               end else begin
                  idx_in = IDX_W'(idx_ff + 1'b1);
               end
            end
         end
         S_RAW: begin
            if (adv) begin
               push_b  = 1'b1;
               crc_upd = 1'b1;
               if (blk_ff == '0) begin
                  // stored block header: final flag, LEN, NLEN
                  case (hdr_ff)
                     3'd0:    b_out = {7'd0, fin_blk};
                     3'd1:    b_out = n_blk[7:0];
                     3'd2:    b_out = n_blk[15:8];
                     3'd3:    b_out = ~n_blk[7:0];
                     default: b_out = ~n_blk[15:8];
                  endcase
                  if (hdr_ff == 3'd4) begin
                     hdr_in = '0;
                     blk_in = n_blk;
                  end else begin
                     hdr_in = 3'(hdr_ff + 1'b1);
                  end
               end else begin
                  b_out   = raw_b;
                  alo_in  = lo_new;
                  ahi_in  = hi_new;
                  blk_in  = BLK_W'(blk_ff - 1'b1);
                  left_in = RAW_W'(left_ff - 1'b1);
                  if (idx_ff[1:0] == 2'd3) begin
                     if (col_nx >= lat_w_ff) begin
                        col_in = '0;
                        row_in = row_nx[CNT_W-1:0];
                        if (row_nx >= lat_h_ff) begin
                           state_in = S_TAIL;
                           idx_in   = '0;
                        end else begin
                           end_step = 1'b1;
                           px_pop   = 1'b1;
                           state_in = S_IDLE;
                        end
                     end else begin
                        col_in   = col_nx[CNT_W-1:0];
                        end_step = 1'b1;
                        px_pop   = 1'b1;
                        state_in = S_IDLE;
                     end
                  end else begin
                     idx_in = IDX_W'(idx_ff + 1'b1);
                  end
               end
            end
         end
         S_TAIL: begin
            if (adv) begin
               push_b = 1'b1;
               if (idx_ff < TP_CRC) begin
                  b_out   = be_byte({ahi_ff, alo_ff}, idx_ff[1:0]);
                  crc_upd = 1'b1;
               end else if (idx_ff < TP_IEND) begin
                  b_out = be_byte(~crc_ff, idx_ff[1:0]);
               end else begin
                  b_out = iend_byte(4'(idx_ff - TP_IEND));
               end
               if (idx_ff == TP_LAST) begin
                  eof_b      = 1'b1;
                  started_in = 1'b0;
                  end_step   = 1'b1;
                  px_pop     = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  idx_in = IDX_W'(idx_ff + 1'b1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      crc_base = crc_one ? CRC_INIT : crc_ff;
      crc_in   = crc_upd ? crc_byte(crc_base, b_out) : crc_ff;

      // bytes owed to the output, cut into runs of at most MAX_OUT
      total   = OWED_W'(owed_ff + {{(OWED_W-1){1'b0}}, push_b});
      quota   = (total > OWED_W'(MAX_OUT)) ? QUOTA_W'(MAX_OUT) : total[QUOTA_W-1:0];
      owed_in = end_step ? OWED_W'(total - {{(OWED_W-QUOTA_W){1'b0}}, quota}) : total;
   end

   always_comb begin
      byte_push.valid = push_b;
      byte_push.eof   = eof_b;
      byte_push.data  = b_out;
      step_push.valid = end_step;
      step_push.quota = quota;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         dv_ff      <= D_IDLE;
         idx_ff     <= '0;
         hdr_ff     <= '0;
         crc_ff     <= CRC_INIT;
         alo_ff     <= 16'd1;
         ahi_ff     <= 16'd0;
         col_ff     <= '0;
         row_ff     <= '0;
         left_ff    <= '0;
         blk_ff     <= '0;
         started_ff <= 1'b0;
         owed_ff    <= '0;
         zlen_ok_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dv_ff      <= dv_in;
         idx_ff     <= idx_in;
         hdr_ff     <= hdr_in;
         crc_ff     <= crc_in;
         alo_ff     <= alo_in;
         ahi_ff     <= ahi_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         left_ff    <= left_in;
         blk_ff     <= blk_in;
         started_ff <= started_in;
         owed_ff    <= owed_in;
         zlen_ok_ff <= zlen_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      lat_w_ff <= lat_w_in;
      lat_h_ff <= lat_h_in;
      raw_ff   <= raw_in;
      dq_ff    <= dq_in;
      zlen_ff  <= zlen_in;
   end

endmodule

`default_nettype wire

@@ rtl/pse_emit.sv @@
// ---------------------------------------------------------------------------
// pse_emit: byte backlog and run queue; drives the result register and marks
// the last byte of each run.
// ---------------------------------------------------------------------------
`default_nettype none

module pse_emit
   import pse_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  pse_byte_type  byte_push,
   input  pse_step_type  step_push,
   output pse_status_type status,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_last_of_run,
   output logic          rsp_end_of_file
);

   localparam int BAW = $clog2(BQ_DEPTH);

   logic [BAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [BAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [BAW:0]       stored_ff, stored_in;
   logic               dout_valid_ff, dout_valid_in;
   logic [8:0]         dout;
   logic               rd_en, wr_en;

   logic               q_valid, q_full, q_pop;
   logic [QUOTA_W-1:0] q_data;
   logic [QUOTA_W-1:0] rem_ff, rem_in, cur_rem;
   logic               fire;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         byte_ff;
   logic               last_ff, eof_ff;

   assign wr_en = byte_push.valid && (stored_ff != (BAW+1)'(BQ_DEPTH));

   always_comb begin
      cur_rem = (rem_ff != '0) ? rem_ff : (q_valid ? q_data : '0);
      q_pop   = (rem_ff == '0) && q_valid;
      fire    = (cur_rem != '0) && dout_valid_ff && (!rsp_valid_ff || !rsp_stall);
      rem_in  = fire ? QUOTA_W'(cur_rem - 1'b1) : cur_rem;

      rd_en         = (stored_ff != '0) && (!dout_valid_ff || fire);
      dout_valid_in = rd_en ? 1'b1 : (fire ? 1'b0 : dout_valid_ff);
      wr_ptr_in     = wr_en ? BAW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in     = rd_en ? BAW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      stored_in     = stored_ff;
      if (wr_en && !rd_en) stored_in = (BAW+1)'(stored_ff + 1'b1);
      else if (rd_en && !wr_en) stored_in = (BAW+1)'(stored_ff - 1'b1);

      rsp_valid_in = fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

      status.byte_full = (stored_ff == (BAW+1)'(BQ_DEPTH));
      status.step_full = q_full;
   end

   pse_ram #(
      .WIDTH (9),
      .DEPTH (BQ_DEPTH)
   ) u_backlog (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data ({byte_push.eof, byte_push.data}),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (dout)
   );

   pse_regq #(
      .WIDTH (QUOTA_W),
      .DEPTH (STEPQ_DEPTH)
   ) u_runq (
      .clock      (clock),
      .reset      (reset),
      .push       (step_push.valid),
      .push_data  (step_push.quota),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (q_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         stored_ff     <= '0;
         dout_valid_ff <= 1'b0;
         rem_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         stored_ff     <= stored_in;
         dout_valid_ff <= dout_valid_in;
         rem_ff        <= rem_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= dout[7:0];
         eof_ff  <= dout[8];
         last_ff <= (cur_rem == QUOTA_W'(1));
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_end_of_file = eof_ff;

endmodule

`default_nettype wire

@@ rtl/png_stored_deflate_encoder.sv @@
// ---------------------------------------------------------------------------
// png_stored_deflate_encoder: RGB pixels in, 8-bit truecolor PNG bytes out,
// image data wrapped in zlib stored blocks.
// ---------------------------------------------------------------------------
//  channel | ports                                  | transfer when
//  --------+----------------------------------------+---------------------------
//  pixel   | req_valid req_stall req_red/green/blue | req_valid & !req_stall
//  byte    | rsp_valid rsp_stall rsp_out_byte ...   | rsp_valid & !rsp_stall
//  config  | csr_valid csr_ready csr_index csr_data | csr_valid & csr_ready
//
// Inside a row a pixel is taken, then its three bytes leave the sequencer one
// a cycle unless it is stalled, after a filter byte at the start of a row; a
// block header adds 5 bytes, the first pixel of an image the 43-byte preamble,
// the last the 20-byte trailer. Output runs one byte a cycle unless stalled.
// Synchronous reset clears all control state. A stalled output stalls the
// sequencer once four runs wait or the 256-byte backlog fills, then req_stall.
`default_nettype none

module png_stored_deflate_encoder
   import pse_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [23:0] req_red,
   input  wire logic [23:0] req_green,
   input  wire logic [23:0] req_blue,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run,
   output logic             rsp_end_of_file,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_data
);

   logic [DIM_W-1:0] width_ff, height_ff;
   logic             px_valid, px_pop;
   pse_pixel_type    px_data;
   pse_byte_type     byte_push;
   pse_step_type     step_push;
   pse_status_type   status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
      end else if (csr_valid) begin
         if (csr_index == CFG_WIDTH) width_ff <= csr_data;
         if (csr_index == CFG_HEIGHT) height_ff <= csr_data;
      end
   end

   pse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .px_valid  (px_valid),
      .px_data   (px_data),
      .px_pop    (px_pop)
   );

   pse_gen u_gen (
      .clock      (clock),
      .reset      (reset),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .px_valid   (px_valid),
      .px_data    (px_data),
      .px_pop     (px_pop),
      .byte_push  (byte_push),
      .step_push  (step_push),
      .status     (status)
   );

   pse_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .byte_push       (byte_push),
      .step_push       (step_push),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_end_of_file (rsp_end_of_file)
   );

endmodule

`default_nettype wire

@@ rtl/pse_checker.sv @@
// ---------------------------------------------------------------------------
// pse_checker: port-level checks of the encoder's output stream.
// ---------------------------------------------------------------------------
`default_nettype none

module pse_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last_of_run,
   input wire logic       rsp_end_of_file
);

   // a stalled byte holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled output byte changed");

   // the file's final byte always closes a run
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_file |-> rsp_last_of_run)
      else $error("end of file not on the last byte of a run");

   // no two file ends back to back
   a_eof_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_end_of_file |=> !(rsp_valid && rsp_end_of_file))
      else $error("two end-of-file bytes in a row");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind png_stored_deflate_encoder pse_checker u_pse_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_end_of_file (rsp_end_of_file)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: stored-deflate PNG encoder testbench
// Streams pixel images through the encoder under several idle patterns and
// image sizes, predicts every file byte (signature, IHDR, stored zlib blocks,
// Adler-32, CRCs, IEND) and compares each output transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import pse_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       eof;
   } png_byte_type;

   typedef struct packed {
      logic [23:0] red;
      logic [23:0] green;
      logic [23:0] blue;
   } rgb_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [23:0] req_red = '0, req_green = '0, req_blue = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;
   logic        rsp_end_of_file;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [14:0] csr_data = '0;

   png_stored_deflate_encoder u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run), .rsp_end_of_file(rsp_end_of_file),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // encoder image of the predictor
   logic [14:0] width_reg = 15'd1, height_reg = 15'd1;
   logic [31:0] idat_crc;
   logic [15:0] adler_lo, adler_hi;
   int unsigned col_cnt, row_cnt, lat_width, lat_height;
   int unsigned raw_left, blk_left;
   logic        in_image = 1'b0;
   png_byte_type  byte_backlog[$];
   png_byte_type  file_bytes_due[$];
   rgb_pixel_type pixel_queue[$];

   int  error_count = 0;
   int  send_idle = 0, recv_idle = 0;
   logic pixel_taken = 1'b0;

   function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) r = (r >> 1) ^ (r[0] ? 32'hedb88320 : 32'd0);
      return r;
   endfunction

   function automatic logic [7:0] sample_to_byte(logic [23:0] s);
      longint v;
      v = longint'($signed(s));
      if (v < 0) v = 0;
      if (v > 65536) v = 65536;
      return 8'((v * 255 + 32768) >> 16);
   endfunction

   function automatic int unsigned dim_limit(logic [14:0] d);
      if (d == 0) return 1;
      if (d > 15'd16384) return 16384;
      return 32'(d);
   endfunction

   function automatic void put_byte(logic [7:0] b);
      png_byte_type e;
      e.data = b;
      e.last = 1'b0;
      e.eof  = 1'b0;
      byte_backlog.insert(byte_backlog.size(), e);
   endfunction

   function automatic void put_word(logic [31:0] x);
      for (int i = 3; i >= 0; i--) put_byte(x[8*i +: 8]);
   endfunction

   function automatic void put_idat(logic [7:0] b);
      idat_crc = crc_update(idat_crc, b);
      put_byte(b);
   endfunction

   function automatic void put_raw(logic [7:0] b);
      int unsigned n;
      if (blk_left == 0) begin
         n = (raw_left < 65535) ? raw_left : 65535;
         put_idat((n == raw_left) ? 8'd1 : 8'd0);
         put_idat(n[7:0]);
         put_idat(n[15:8]);
         put_idat(~n[7:0]);
         put_idat(~n[15:8]);
         blk_left = n;
      end
      put_idat(b);
      adler_lo = 16'((32'(adler_lo) + b) % 65521);
      adler_hi = 16'((32'(adler_hi) + adler_lo) % 65521);
      if (blk_left != 0) blk_left--;
      if (raw_left != 0) raw_left--;
   endfunction

   function automatic void open_image();
      logic [7:0]  ihdr[17];
      logic [31:0] c;
      int unsigned nblk;
      lat_width  = dim_limit(width_reg);
      lat_height = dim_limit(height_reg);
      raw_left = (3 * lat_width + 1) * lat_height;
      nblk = (raw_left + 65534) / 65535;
      foreach (ihdr[i]) ihdr[i] = 8'd0;
      ihdr[0] = "I"; ihdr[1] = "H"; ihdr[2] = "D"; ihdr[3] = "R";
      for (int i = 0; i < 4; i++) begin
         ihdr[4 + i] = 8'(lat_width >> (24 - 8 * i));
         ihdr[8 + i] = 8'(lat_height >> (24 - 8 * i));
      end
      ihdr[12] = 8'd8;
      ihdr[13] = 8'd2;
      put_byte(8'd137); put_byte(8'd80); put_byte(8'd78); put_byte(8'd71);
      put_byte(8'd13); put_byte(8'd10); put_byte(8'd26); put_byte(8'd10);
      put_word(32'd13);
      c = 32'hffffffff;
      for (int i = 0; i < 17; i++) begin
         put_byte(ihdr[i]);
         c = crc_update(c, ihdr[i]);
      end
      put_word(~c);
      put_word(32'(2 + 5 * nblk + raw_left + 4));
      idat_crc = 32'hffffffff;
      put_idat("I"); put_idat("D"); put_idat("A"); put_idat("T");
      put_idat(8'h78); put_idat(8'h01);
      adler_lo = 16'd1;
      adler_hi = 16'd0;
      col_cnt  = 0;
      row_cnt  = 0;
      blk_left = 0;
      in_image = 1'b1;
   endfunction

   function automatic void close_image();
      logic [31:0] adler;
      adler = {adler_hi, adler_lo};
      for (int i = 3; i >= 0; i--) put_idat(adler[8*i +: 8]);
      put_word(~idat_crc);
      put_word(32'd0);
      put_byte("I"); put_byte("E"); put_byte("N"); put_byte("D");
      put_byte(8'hae); put_byte(8'h42); put_byte(8'h60); put_byte(8'h82);
      byte_backlog[byte_backlog.size() - 1].eof = 1'b1;
      in_image = 1'b0;
   endfunction

   // one accepted pixel: advance the encoder and release up to MAX_OUT bytes
   function automatic void encode_pixel(rgb_pixel_type p);
      int k;
      png_byte_type e;
      if (in_image || byte_backlog.size() == 0) begin
         if (!in_image) open_image();
         if (col_cnt == 0) put_raw(8'd0);
         put_raw(sample_to_byte(p.red));
         put_raw(sample_to_byte(p.green));
         put_raw(sample_to_byte(p.blue));
         col_cnt++;
         if (col_cnt >= lat_width) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= lat_height) close_image();
         end
      end
      k = (byte_backlog.size() < MAX_OUT) ? byte_backlog.size() : MAX_OUT;
      for (int i = 0; i < k; i++) begin
         e = byte_backlog.pop_front();
         e.last = (i == k - 1);
         file_bytes_due.insert(file_bytes_due.size(), e);
      end
   endfunction

   // accept pixels and check output bytes
   always @(posedge clock) begin
      png_byte_type want;
      pixel_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pixel_taken = 1'b1;
            encode_pixel('{req_red, req_green, req_blue});
         end
         if (rsp_valid && !rsp_stall) begin
            if (file_bytes_due.size() == 0) begin
               error_count++;
               $display("%0t: unexpected byte: expected none, actual %02h last %0b eof %0b",
                        $realtime, rsp_out_byte, rsp_last_of_run, rsp_end_of_file);
            end else begin
               want = file_bytes_due.pop_front();
               if (rsp_out_byte !== want.data) begin
                  error_count++;
                  $display("%0t: out_byte expected %02h actual %02h",
                           $realtime, want.data, rsp_out_byte);
               end
               if (rsp_last_of_run !== want.last) begin
                  error_count++;
                  $display("%0t: last_of_run expected %0b actual %0b",
                           $realtime, want.last, rsp_last_of_run);
               end
               if (rsp_end_of_file !== want.eof) begin
                  error_count++;
                  $display("%0t: end_of_file expected %0b actual %0b",
                           $realtime, want.eof, rsp_end_of_file);
               end
            end
         end
      end
   end

   // pixel driver and output stall
   always @(negedge clock) begin
      rgb_pixel_type p;
      if (!reset) begin
         if (!req_valid || pixel_taken) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
               p = pixel_queue.pop_front();
               req_valid <= 1'b1;
               req_red   <= p.red;
               req_green <= p.green;
               req_blue  <= p.blue;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   task automatic reg_write(logic [1:0] idx, logic [14:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CFG_WIDTH) width_reg = value;
      else if (idx == CFG_HEIGHT) height_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for all bytes; send a throwaway pixel while a backlog remains
   task automatic drain();
      rgb_pixel_type flush;
      forever begin
         wait (pixel_queue.size() == 0 && !req_valid && file_bytes_due.size() == 0);
         repeat (60) @(posedge clock);
         if (byte_backlog.size() == 0) break;
         flush = '{24'($urandom), 24'($urandom), 24'($urandom)};
         pixel_queue.insert(pixel_queue.size(), flush);
         @(posedge clock);
      end
   endtask

   function automatic logic [23:0] random_sample();
      case ($urandom_range(3))
         0:       return 24'($urandom);
         1:       return 24'($urandom_range(65536));
         2:       return 24'($urandom_range(65540, 65530));
         default: return 24'(-$signed({1'b0, 23'($urandom_range(8388607, 1))}));
      endcase
   endfunction

   task automatic random_image(logic [14:0] w, logic [14:0] h);
      int unsigned n;
      reg_write(CFG_WIDTH, w);
      reg_write(CFG_HEIGHT, h);
      n = dim_limit(w) * dim_limit(h);
      repeat (n) begin
         pixel_queue.insert(pixel_queue.size(),
                            '{random_sample(), random_sample(), random_sample()});
      end
      drain();
   endtask

   task automatic add_pixel(logic [23:0] r, logic [23:0] g, logic [23:0] b);
      rgb_pixel_type p;
      p = '{r, g, b};
      pixel_queue.insert(pixel_queue.size(), p);
   endtask

   initial begin
      send_idle = 29;
      recv_idle = 88;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // one-pixel file at reset dimensions: spills past one transfer run
      add_pixel(24'h800000, 24'h7fffff, 24'h010000);
      drain();

      // sample extremes and rounding points
      reg_write(CFG_WIDTH, 15'd3);
      reg_write(CFG_HEIGHT, 15'd3);
      add_pixel(24'h800000, 24'h000000, 24'h010000);
      add_pixel(24'h7fffff, 24'h010001, 24'h008000);
      add_pixel(24'h00ffff, 24'h000080, 24'hffffff);
      add_pixel(24'h000081, 24'h00007f, 24'h000101);
      add_pixel(24'h555555, 24'haaaaaa, 24'h00ff00);
      add_pixel(24'h000100, 24'h00fe80, 24'h00fe7f);
      add_pixel(24'h0000ff, 24'hff0000, 24'h010000);
      add_pixel(24'h000001, 24'h00c000, 24'h004000);
      add_pixel(24'h00ff7f, 24'h00ff80, 24'h000000);
      drain();

      // zero dimensions act as one
      random_image(15'd0, 15'd0);
      repeat (6) random_image(15'($urandom_range(8, 1)), 15'($urandom_range(4, 1)));

      send_idle = 88;
      recv_idle = 29;
      random_image(15'd2, 15'd1);
      repeat (6) random_image(15'($urandom_range(8, 1)), 15'($urandom_range(4, 1)));

      send_idle = 0;
      recv_idle = 0;
      repeat (6) random_image(15'($urandom_range(8, 1)), 15'($urandom_range(4, 1)));
      random_image(15'd4, 15'd2);

      if (error_count == 0 && file_bytes_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
